@@ rtl/otsu_pkg.sv @@
// Shared types, widths and codes for the Otsu histogram threshold block.
// No dependencies; used by every module of the block.
package otsu_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned NBINS   = 256;
  localparam int unsigned BIN_W   = 21;
  localparam int unsigned CNT_W   = BIN_W + PIX_W;
  localparam int unsigned SUM_W   = CNT_W + PIX_W;
  localparam int unsigned N_W     = CNT_W + SUM_W;
  localparam int unsigned NUM_W   = 2 * N_W;
  localparam int unsigned DEN_W   = 2 * CNT_W;
  localparam int unsigned MA_W    = NUM_W;
  localparam int unsigned MB_W    = N_W;
  localparam int unsigned MP_W    = MA_W + MB_W;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};
  localparam logic [PIX_W-1:0] START_T = 8'd128;
  localparam logic [PIX_W-1:0] PIX_HI  = 8'd255;
  localparam logic [PIX_W-1:0] PIX_LO  = 8'd0;
  localparam logic [PIX_W-1:0] T_LAST  = 8'd255;

  localparam logic CMD_ACC = 1'b0;
  localparam logic CMD_BIN = 1'b1;

  typedef struct packed {
    logic             command;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } item_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MP_W-1:0] p;
  } mul_rsp_t;

endpackage

@@ rtl/otsu_front.sv @@
// Input side: accepts command transfers and queues them for the back end.
// Depends on otsu_pkg.
module otsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             command_i,
  input  logic [7:0]       pixel_i,
  input  logic             last_i,
  output logic             busy,
  output otsu_pkg::item_t  item_o,
  output logic             item_valid_o,
  input  logic             pop_i
);

  otsu_pkg::item_t q_q [otsu_pkg::Q_DEPTH];
  logic [otsu_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [otsu_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign busy         = (cnt_q == otsu_pkg::QCNT_W'(otsu_pkg::Q_DEPTH));
  assign push         = start && !busy;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= '{command: command_i, pixel: pixel_i, last: last_i};
    end
  end

endmodule

@@ rtl/otsu_mul.sv @@
// Shared shift-add multiplier, one multiplier bit per cycle, early exit.
// Depends on otsu_pkg.
module otsu_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otsu_pkg::mul_req_t  req_i,
  output otsu_pkg::mul_rsp_t  rsp_o
);

  logic                        run_q, run_d;
  logic [otsu_pkg::MP_W-1:0]   a_q, acc_q;
  logic [otsu_pkg::MB_W-1:0]   b_q;
  logic                        fin;

  assign fin = run_q && (b_q == '0);

  always_comb begin
    run_d = run_q;
    if (req_i.start) begin
      run_d = 1'b1;
    end else if (fin) begin
      run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= otsu_pkg::MP_W'(req_i.a);
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (run_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o = '{busy: run_q, done: fin, p: acc_q};

endmodule

@@ rtl/otsu_back.sv @@
// Back end: histogram memory, binarize path and the Otsu threshold sequencer.
// Depends on otsu_pkg; drives the shared otsu_mul unit.
module otsu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otsu_pkg::item_t     item_i,
  input  logic                item_valid_i,
  output logic                pop_o,
  output otsu_pkg::mul_req_t  mul_req_o,
  input  otsu_pkg::mul_rsp_t  mul_rsp_i,
  output logic                strobe_o,
  output logic                is_threshold_o,
  output logic [7:0]          threshold_o,
  output logic [7:0]          pixel_out_o
);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_ACC     = 14'b00000000000010,
    ST_SUM_RD  = 14'b00000000000100,
    ST_SUM_ADD = 14'b00000000001000,
    ST_INIT    = 14'b00000000010000,
    ST_SC_RD   = 14'b00000000100000,
    ST_SC_ADD  = 14'b00000001000000,
    ST_P       = 14'b00000010000000,
    ST_Q       = 14'b00000100000000,
    ST_N       = 14'b00001000000000,
    ST_D       = 14'b00010000000000,
    ST_L       = 14'b00100000000000,
    ST_R       = 14'b01000000000000,
    ST_DONE    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;
  logic   init_q;

  logic [otsu_pkg::BIN_W-1:0] mem_q [otsu_pkg::NBINS];
  logic [otsu_pkg::NBINS-1:0] vld_q;
  logic [otsu_pkg::BIN_W-1:0] rd_q;
  logic                       rdv_q;
  logic [otsu_pkg::PIX_W-1:0] raddr;

  logic [otsu_pkg::PIX_W-1:0] t_q, pix_q, best_q, thr_q;
  logic                       last_q;
  logic [otsu_pkg::CNT_W-1:0] tot0_q, m0_q, c0m_q, m0_nx, ht;
  logic [otsu_pkg::SUM_W-1:0] tot1_q, m1_q, c1m_q, m1_nx;
  logic [otsu_pkg::N_W-1:0]   p_q, n_q, q_val;
  logic [otsu_pkg::NUM_W-1:0] num_q, bn_q;
  logic [otsu_pkg::DEN_W-1:0] den_q, bd_q;
  logic [otsu_pkg::MP_W-1:0]  l_q;
  logic [otsu_pkg::BIN_W-1:0] h, h_inc;
  logic                       mul_ok, empty_sc, empty_init;

  logic                       strobe_q, isthr_q;
  logic [otsu_pkg::PIX_W-1:0] thr_out_q, pout_q;

  assign h          = rdv_q ? rd_q : '0;
  assign h_inc      = (h == otsu_pkg::BIN_MAX) ? h : h + 1'b1;
  assign ht         = otsu_pkg::CNT_W'(h) * otsu_pkg::CNT_W'(t_q);
  assign m0_nx      = m0_q + otsu_pkg::CNT_W'(h);
  assign m1_nx      = m1_q + otsu_pkg::SUM_W'(ht);
  assign empty_sc   = (m0_nx == '0) || (m0_nx >= tot0_q);
  assign empty_init = (c0m_q == '0) || (c0m_q >= tot0_q);
  assign mul_ok     = issued_q && mul_rsp_i.done;
  assign q_val      = mul_rsp_i.p[otsu_pkg::N_W-1:0];
  assign raddr      = (state_q == ST_IDLE) ? item_i.pixel : t_q;

  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    pop_o     = 1'b0;
    mul_req_o = '{start: 1'b0, a: '0, b: '0};
    unique case (state_q)
      ST_P: mul_req_o = '{start: 1'b0, a: otsu_pkg::MA_W'(tot0_q), b: otsu_pkg::MB_W'(m1_q)};
      ST_Q: mul_req_o = '{start: 1'b0, a: otsu_pkg::MA_W'(m0_q), b: otsu_pkg::MB_W'(tot1_q)};
      ST_N: mul_req_o = '{start: 1'b0, a: otsu_pkg::MA_W'(n_q), b: n_q};
      ST_D: mul_req_o = '{start: 1'b0, a: otsu_pkg::MA_W'(m0_q),
                          b: otsu_pkg::MB_W'(tot0_q - m0_q)};
      ST_L: mul_req_o = '{start: 1'b0, a: num_q, b: otsu_pkg::MB_W'(bd_q)};
      ST_R: mul_req_o = '{start: 1'b0, a: bn_q, b: otsu_pkg::MB_W'(den_q)};
      default: mul_req_o = '{start: 1'b0, a: '0, b: '0};
    endcase
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          if (item_i.command == otsu_pkg::CMD_ACC) begin
            state_d = ST_ACC;
          end
        end
      end
      ST_ACC:     state_d = last_q ? ST_SUM_RD : ST_IDLE;
      ST_SUM_RD:  state_d = ST_SUM_ADD;
      ST_SUM_ADD: state_d = (t_q == otsu_pkg::T_LAST) ? ST_INIT : ST_SUM_RD;
      ST_INIT:    state_d = empty_init ? ST_SC_RD : ST_P;
      ST_SC_RD:   state_d = ST_SC_ADD;
      ST_SC_ADD: begin
        if (!empty_sc) begin
          state_d = ST_P;
        end else begin
          state_d = (t_q == otsu_pkg::T_LAST) ? ST_DONE : ST_SC_RD;
        end
      end
      ST_P, ST_Q, ST_N, ST_D, ST_L, ST_R: begin
        if (!issued_q) begin
          mul_req_o.start = 1'b1;
          issued_d        = 1'b1;
        end else if (mul_rsp_i.done) begin
          issued_d = 1'b0;
          priority case (state_q)
            ST_P:    state_d = ST_Q;
            ST_Q:    state_d = ST_N;
            ST_N:    state_d = ST_D;
            ST_D:    state_d = init_q ? ST_SC_RD : ST_L;
            ST_L:    state_d = ST_R;
            default: state_d = (t_q == otsu_pkg::T_LAST) ? ST_DONE : ST_SC_RD;
          endcase
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      vld_q    <= '0;
      thr_q    <= otsu_pkg::START_T;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      strobe_q <= (state_q == ST_IDLE && item_valid_i &&
                   item_i.command == otsu_pkg::CMD_BIN) || (state_q == ST_DONE);
      if (state_q == ST_ACC) begin
        vld_q[pix_q] <= 1'b1;
      end
      if (state_q == ST_DONE) begin
        vld_q    <= '0;
        thr_q    <= best_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= mem_q[raddr];
    rdv_q <= vld_q[raddr];
    if (state_q == ST_ACC) begin
      mem_q[pix_q] <= h_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        pix_q  <= item_i.pixel;
        last_q <= item_i.last;
        t_q    <= '0;
        tot0_q <= '0;
        tot1_q <= '0;
        isthr_q   <= 1'b0;
        thr_out_q <= thr_q;
        pout_q    <= (item_i.pixel >= thr_q) ? otsu_pkg::PIX_HI : otsu_pkg::PIX_LO;
      end
      ST_SUM_ADD: begin
        tot0_q <= tot0_q + otsu_pkg::CNT_W'(h);
        tot1_q <= tot1_q + otsu_pkg::SUM_W'(ht);
        if (t_q == otsu_pkg::START_T) begin
          c0m_q <= tot0_q + otsu_pkg::CNT_W'(h);
          c1m_q <= tot1_q + otsu_pkg::SUM_W'(ht);
        end
        t_q <= t_q + 1'b1;
      end
      ST_INIT: begin
        best_q <= otsu_pkg::START_T;
        init_q <= !empty_init;
        bn_q   <= '0;
        bd_q   <= otsu_pkg::DEN_W'(1);
        m0_q   <= empty_init ? '0 : c0m_q;
        m1_q   <= empty_init ? '0 : c1m_q;
      end
      ST_SC_ADD: begin
        m0_q <= m0_nx;
        m1_q <= m1_nx;
        if (empty_sc) begin
          t_q <= t_q + 1'b1;
        end
      end
      ST_P: if (mul_ok) p_q <= mul_rsp_i.p[otsu_pkg::N_W-1:0];
      ST_Q: if (mul_ok) n_q <= (p_q > q_val) ? p_q - q_val : q_val - p_q;
      ST_N: if (mul_ok) num_q <= mul_rsp_i.p[otsu_pkg::NUM_W-1:0];
      ST_D: begin
        if (mul_ok) begin
          den_q <= mul_rsp_i.p[otsu_pkg::DEN_W-1:0];
          if (init_q) begin
            bn_q   <= num_q;
            bd_q   <= mul_rsp_i.p[otsu_pkg::DEN_W-1:0];
            init_q <= 1'b0;
            m0_q   <= '0;
            m1_q   <= '0;
          end
        end
      end
      ST_L: if (mul_ok) l_q <= mul_rsp_i.p;
      ST_R: begin
        if (mul_ok) begin
          if (l_q > mul_rsp_i.p) begin
            bn_q   <= num_q;
            bd_q   <= den_q;
            best_q <= t_q;
          end
          t_q <= t_q + 1'b1;
        end
      end
      ST_DONE: begin
        isthr_q   <= 1'b1;
        thr_out_q <= best_q;
        pout_q    <= otsu_pkg::PIX_LO;
      end
      default: begin
      end
    endcase
  end

  assign strobe_o       = strobe_q;
  assign is_threshold_o = isthr_q;
  assign threshold_o    = thr_out_q;
  assign pixel_out_o    = pout_q;

  a_thr_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && is_threshold_o |-> $past(state_q == ST_DONE))
    else $error("threshold result without finished search");
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req_o.start |-> !mul_rsp_i.busy)
    else $error("multiplier started while busy");
  a_hist_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == ST_DONE) |-> vld_q == '0)
    else $error("histogram not cleared after search");
  a_pix_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (pixel_out_o == otsu_pkg::PIX_LO || pixel_out_o == otsu_pkg::PIX_HI))
    else $error("binarized pixel out of range");

endmodule

@@ rtl/otsu_histogram_threshold.sv @@
// Top level of the Otsu histogram threshold block.
// Depends on otsu_pkg, otsu_front, otsu_mul and otsu_back.
//
// Command channel: a transfer happens when start is high and busy is low.
// command 0 counts pixel into a 256-bin saturating histogram; with last set,
// the Otsu threshold of the frame is searched, stored, sent out and the
// histogram is cleared. command 1 binarizes pixel against the stored value.
// Results appear for one cycle with strobe_o high; the receiver cannot stall.
// A two-entry queue sits between command intake and execution.
// Binarize: result registered after the queue; one item per cycle when idle.
// Accumulate: a histogram read-modify-write, done before the next item is taken.
// Search: a sweep summing every histogram bin, then per occupied-class candidate
// up to six multiplies on one shift-add multiplier, one bit per cycle;
// busy stays high once the queue fills.
// Reset: histogram empty, stored threshold 128, no result pending.
module otsu_histogram_threshold (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       command_i,
  input  logic [7:0] pixel_i,
  input  logic       last_i,
  output logic       busy,
  output logic       strobe_o,
  output logic       is_threshold_o,
  output logic [7:0] threshold_o,
  output logic [7:0] pixel_out_o
);

  otsu_pkg::item_t    item;
  logic               item_valid, pop;
  otsu_pkg::mul_req_t mul_req;
  otsu_pkg::mul_rsp_t mul_rsp;

  otsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .command_i    (command_i),
    .pixel_i      (pixel_i),
    .last_i       (last_i),
    .busy         (busy),
    .item_o       (item),
    .item_valid_o (item_valid),
    .pop_i        (pop)
  );

  otsu_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  otsu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .item_valid_i   (item_valid),
    .pop_o          (pop),
    .mul_req_o      (mul_req),
    .mul_rsp_i      (mul_rsp),
    .strobe_o       (strobe_o),
    .is_threshold_o (is_threshold_o),
    .threshold_o    (threshold_o),
    .pixel_out_o    (pixel_out_o)
  );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for otsu_histogram_threshold: histogram frames and binarize commands.
// Carries its own Otsu search predictor in wide integers; depends on otsu_pkg and the RTL.
module tb;

  localparam int unsigned STALL_LIMIT = 2000000;

  typedef struct {
    logic       is_thr;
    logic [7:0] thr;
    logic [7:0] pix;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       command_i = otsu_pkg::CMD_ACC;
  logic [7:0] pixel_i = '0;
  logic       last_i = 1'b0;
  logic       busy;
  logic       strobe_o;
  logic       is_threshold_o;
  logic [7:0] threshold_o;
  logic [7:0] pixel_out_o;

  result_t     expected_q[$];
  int unsigned bin_count[otsu_pkg::NBINS];
  logic [7:0]  thr_reg = otsu_pkg::START_T;
  int          gap_pct = 0;
  int          items_sent = 0;
  int          errors = 0;
  int unsigned stall_cycles = 0;

  otsu_histogram_threshold dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .command_i(command_i),
    .pixel_i(pixel_i), .last_i(last_i), .busy(busy), .strobe_o(strobe_o),
    .is_threshold_o(is_threshold_o), .threshold_o(threshold_o),
    .pixel_out_o(pixel_out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void class_score(input logic [255:0] m0, input logic [255:0] m1,
                                      input logic [255:0] tot0, input logic [255:0] tot1,
                                      output logic [255:0] num, output logic [255:0] den);
    logic [255:0] p;
    logic [255:0] q;
    logic [255:0] d;
    if (m0 == 0 || m0 >= tot0) begin
      num = 0;
      den = 1;
    end else begin
      p = tot0 * m1;
      q = m0 * tot1;
      d = (p > q) ? p - q : q - p;
      num = d * d;
      den = m0 * (tot0 - m0);
    end
  endfunction

  function automatic logic [7:0] otsu_search();
    logic [255:0] c0[otsu_pkg::NBINS];
    logic [255:0] c1[otsu_pkg::NBINS];
    logic [255:0] s0;
    logic [255:0] s1;
    logic [255:0] bn;
    logic [255:0] bd;
    logic [255:0] tn;
    logic [255:0] td;
    logic [7:0]   best;
    s0 = 0;
    s1 = 0;
    best = otsu_pkg::START_T;
    for (int t = 0; t < otsu_pkg::NBINS; t++) begin
      s0 += bin_count[t];
      s1 += 256'(bin_count[t]) * 256'(t);
      c0[t] = s0;
      c1[t] = s1;
    end
    class_score(c0[otsu_pkg::START_T], c1[otsu_pkg::START_T], s0, s1, bn, bd);
    for (int t = 0; t < otsu_pkg::NBINS; t++) begin
      class_score(c0[t], c1[t], s0, s1, tn, td);
      if (tn * bd > bn * td) begin
        bn = tn;
        bd = td;
        best = t[7:0];
      end
    end
    return best;
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] pix, input logic lst);
    result_t r;
    start <= 1'b1;
    command_i <= cmd;
    pixel_i <= pix;
    last_i <= lst;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (cmd == otsu_pkg::CMD_BIN) begin
      r.is_thr = 1'b0;
      r.thr = thr_reg;
      r.pix = (pix >= thr_reg) ? otsu_pkg::PIX_HI : otsu_pkg::PIX_LO;
      expected_q.push_back(r);
    end else begin
      if (bin_count[pix] < otsu_pkg::BIN_MAX) bin_count[pix]++;
      if (lst) begin
        thr_reg = otsu_search();
        foreach (bin_count[i]) bin_count[i] = 0;
        r.is_thr = 1'b1;
        r.thr = thr_reg;
        r.pix = otsu_pkg::PIX_LO;
        expected_q.push_back(r);
      end
    end
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic test_directed();
    send_item(otsu_pkg::CMD_BIN, 8'd127, 1'b0);
    send_item(otsu_pkg::CMD_BIN, 8'd128, 1'b1);
    send_item(otsu_pkg::CMD_BIN, 8'd0, 1'b0);
    send_item(otsu_pkg::CMD_BIN, 8'd255, 1'b0);
    send_item(otsu_pkg::CMD_ACC, 8'd0, 1'b1);
    send_item(otsu_pkg::CMD_ACC, 8'd0, 1'b0);
    send_item(otsu_pkg::CMD_ACC, 8'd1, 1'b1);
    send_item(otsu_pkg::CMD_BIN, 8'd0, 1'b0);
    send_item(otsu_pkg::CMD_BIN, 8'd1, 1'b0);
    send_item(otsu_pkg::CMD_ACC, 8'd255, 1'b0);
    send_item(otsu_pkg::CMD_ACC, 8'd254, 1'b0);
    send_item(otsu_pkg::CMD_ACC, 8'd255, 1'b1);
    send_item(otsu_pkg::CMD_BIN, 8'd254, 1'b0);
    send_item(otsu_pkg::CMD_BIN, 8'd255, 1'b0);
    send_item(otsu_pkg::CMD_ACC, 8'd7, 1'b0);
    send_item(otsu_pkg::CMD_ACC, 8'd7, 1'b0);
    send_item(otsu_pkg::CMD_BIN, 8'd200, 1'b1);
    send_item(otsu_pkg::CMD_ACC, 8'd9, 1'b0);
    send_item(otsu_pkg::CMD_ACC, 8'd10, 1'b1);
    send_item(otsu_pkg::CMD_BIN, 8'd9, 1'b0);
    send_item(otsu_pkg::CMD_BIN, 8'd8, 1'b0);
  endtask

  task automatic test_random(input int pct, input int n_items);
    int stop_at;
    int base;
    int width;
    int len;
    gap_pct = pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(12, 1))
          send_item(otsu_pkg::CMD_BIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        width = $urandom_range(5);
        base = $urandom_range(255 - width);
        len = $urandom_range(40, 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0)
            send_item(otsu_pkg::CMD_BIN, 8'($urandom_range(255)), 1'($urandom_range(1)));
          send_item(otsu_pkg::CMD_ACC, 8'(base + $urandom_range(width)), 1'(k == len - 1));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result thr=%0d pix=%0d", $time, threshold_o, pixel_out_o);
        errors++;
      end else begin
        if (is_threshold_o !== expected_q[0].is_thr) begin
          $display("%0t: is_threshold expected %0d got %0d", $time,
                   expected_q[0].is_thr, is_threshold_o);
          errors++;
        end
        if (threshold_o !== expected_q[0].thr) begin
          $display("%0t: threshold expected %0d got %0d", $time,
                   expected_q[0].thr, threshold_o);
          errors++;
        end
        if (pixel_out_o !== expected_q[0].pix) begin
          $display("%0t: pixel_out expected %0d got %0d", $time,
                   expected_q[0].pix, pixel_out_o);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (bin_count[i]) bin_count[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(20, 510);
    test_random(54, 510);
    test_random(0, 510);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
